// ----- rtl/mlp_pkg.sv -----
// Shared types, constants and activation tables for the perceptron inference engine.
// Depends on nothing; the sequencer, datapath and top refer to it by scoped names, the testbench imports it.
`default_nettype none

package mlp_pkg;

    localparam int MAX_LAYERS = 4;
    localparam int MAX_WIDTH  = 64;
    localparam int TABLE_SIZE = 1024;

    localparam int IDX_W   = 6;
    localparam int LAYER_W = 2;
    localparam int CNT_W   = 7;
    localparam int VAL_W   = 16;
    localparam int ACC_W   = 48;
    localparam int PROD_W  = 32;

    localparam int WT_DEPTH   = MAX_LAYERS * MAX_WIDTH * MAX_WIDTH;
    localparam int WT_AW      = 14;
    localparam int BIAS_DEPTH = MAX_LAYERS * MAX_WIDTH;
    localparam int BIAS_AW    = 8;
    localparam int BUF_DEPTH  = 4 * MAX_WIDTH;
    localparam int BUF_AW     = 8;
    localparam int TAB_AW     = 10;

    typedef enum logic [1:0] {
        OP_WEIGHT = 2'd0,
        OP_BIAS   = 2'd1,
        OP_INPUT  = 2'd2,
        OP_RUN    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ACT_SIGMOID = 2'd0,
        ACT_LEAKY   = 2'd1,
        ACT_TANH    = 2'd2,
        ACT_SINE    = 2'd3
    } t_act;

    typedef enum logic [2:0] {
        REG_LAYER_COUNT = 3'd0,
        REG_INPUT_WIDTH = 3'd1,
        REG_WIDTH_ONE   = 3'd2,
        REG_WIDTH_TWO   = 3'd3,
        REG_WIDTH_THREE = 3'd4,
        REG_WIDTH_FOUR  = 3'd5,
        REG_ACTIVATION  = 3'd6,
        REG_LEAK_SLOPE  = 3'd7
    } t_reg;

    // Regions of the layer buffer memory.
    typedef enum logic [1:0] {
        BUF_INPUT = 2'd0,
        BUF_A     = 2'd1,
        BUF_B     = 2'd2
    } t_region;

    typedef struct packed {
        logic [2:0]            layer_count;
        logic [4:0][CNT_W-1:0] width;
        t_act                  act;
        logic [15:0]           leak_slope;
    } t_cfg;

    typedef struct packed {
        logic               load;
        logic               bias_rd;
        logic [BIAS_AW-1:0] bias_addr;
        logic               mac_rd;
        logic [WT_AW-1:0]   wt_addr;
        logic               buf_rd;
        logic [BUF_AW-1:0]  buf_raddr;
        logic               fin_sat;
        logic               fin_wr;
        logic [BUF_AW-1:0]  buf_waddr;
        logic               out_load;
        logic [IDX_W-1:0]   out_index;
        logic               out_last;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    typedef logic signed [VAL_W-1:0] t_tab [TABLE_SIZE];

    localparam longint unsigned Q31_ONE     = 64'd1 << 31;
    localparam longint unsigned EXP_M1_Q31  = 64'd790015084;
    localparam longint unsigned PI_Q28      = 64'd843314857;
    localparam longint unsigned TWO_PI_Q28  = 64'd1686629713;
    localparam longint unsigned HALF_PI_Q28 = 64'd421657428;

    // Shift and subtract division, used only while the tables are elaborated.
    function automatic longint unsigned udiv(input longint unsigned num,
                                             input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], num[i]};
            if (r >= den) begin
                r    = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^(-y) in Q31 for y in Q12.
    function automatic longint unsigned exp_neg(input longint unsigned y);
        longint unsigned n;
        longint unsigned f;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned r;
        n    = y >> 12;
        f    = (y & 64'd4095) << 19;
        term = Q31_ONE;
        sum  = Q31_ONE;
        for (int k = 1; k <= 16; k++) begin
            term = udiv((term * f) >> 31, 64'(k));
            sum  = sum + term;
        end
        r = udiv((64'd1 << 62) + (sum >> 1), sum);
        for (int k = 0; k < 32; k++) begin
            if (64'(k) < n) begin
                r = (r * EXP_M1_Q31 + (64'd1 << 30)) >> 31;
            end
        end
        return r;
    endfunction

    // sin(x) in Q12 for x in Q12.
    function automatic int sine_q12(input int x);
        longint unsigned a;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        bit              neg;
        neg = (x < 0);
        a   = 64'(neg ? -x : x) << 16;
        if (a >= TWO_PI_Q28) begin
            a = a - TWO_PI_Q28;
        end
        if (a >= PI_Q28) begin
            a   = a - PI_Q28;
            neg = !neg;
        end
        if (a > HALF_PI_Q28) begin
            a = PI_Q28 - a;
        end
        x2   = (a * a) >> 28;
        term = a;
        sum  = a;
        for (int k = 1; k <= 10; k++) begin
            term = udiv((term * x2) >> 28, 64'((2 * k) * (2 * k + 1)));
            if ((k % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        sum = (sum + (64'd1 << 15)) >> 16;
        if (sum > 64'd4096) begin
            sum = 64'd4096;
        end
        return neg ? -int'(sum) : int'(sum);
    endfunction

    // Each entry holds the function at the midpoint of its bucket of input codes.
    function automatic t_tab build_tab(input t_act kind);
        t_tab            t;
        int              lo;
        int              hi;
        int              u;
        int              m;
        longint unsigned ax;
        longint unsigned e;
        longint unsigned den;
        longint unsigned e2;
        longint unsigned tv;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            lo  = (i * 65536) / TABLE_SIZE;
            hi  = ((i + 1) * 65536) / TABLE_SIZE;
            u   = lo + ((hi - lo) >> 1);
            m   = (u < 32768) ? u : u - 65536;
            ax  = 64'((m < 0) ? -m : m);
            e   = exp_neg(ax);
            den = Q31_ONE + e;
            case (kind)
                ACT_SIGMOID: begin
                    if (m >= 0) begin
                        tv = udiv((Q31_ONE << 12) + (den >> 1), den);
                    end else begin
                        tv = udiv((e << 12) + (den >> 1), den);
                    end
                    t[i] = VAL_W'(tv);
                end
                ACT_TANH: begin
                    e2  = exp_neg(2 * ax);
                    den = Q31_ONE + e2;
                    tv  = udiv(((Q31_ONE - e2) << 12) + (den >> 1), den);
                    t[i] = (m < 0) ? -VAL_W'(tv) : VAL_W'(tv);
                end
                default: begin
                    t[i] = VAL_W'(sine_q12(m));
                end
            endcase
        end
        return t;
    endfunction

    localparam t_tab SIG_TAB  = build_tab(ACT_SIGMOID);
    localparam t_tab TANH_TAB = build_tab(ACT_TANH);
    localparam t_tab SIN_TAB  = build_tab(ACT_SINE);

endpackage

`default_nettype wire

// ----- rtl/mlp_if.sv -----
// Handshake channel interfaces for the item input and result output of the engine.
// Depends on nothing; the payload widths match the package constants.
`default_nettype none

interface mlp_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [1:0]         layer;
    logic [5:0]         source_index;
    logic [5:0]         target_index;
    logic signed [15:0] value;

    modport source (output valid, operation, layer, source_index, target_index, value,
                    input ready);
    modport sink   (input valid, operation, layer, source_index, target_index, value,
                    output ready);
endinterface

interface mlp_out_if;
    logic               valid;
    logic               ready;
    logic [5:0]         neuron_index;
    logic signed [15:0] neuron_value;
    logic               last;

    modport source (output valid, neuron_index, neuron_value, last, input ready);
    modport sink   (input valid, neuron_index, neuron_value, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/mlp_ram.sv -----
// Generic single write port, single read port memory with registered read data.
// Depends on nothing.
`default_nettype none

module mlp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mlp_ctrl.sv -----
// Sequencer of the engine: takes items, walks layers, neurons and products, emits results.
// Depends on mlp_pkg; drives the datapath through t_cmd and reads t_sts.
`default_nettype none

module mlp_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mlp_pkg::t_cfg i_cfg,
    input  wire logic          i_valid,
    input  wire logic [1:0]    i_operation,
    output logic               o_ready,
    output mlp_pkg::t_cmd      o_cmd,
    input  wire mlp_pkg::t_sts i_sts
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_LAYER   = 9'b000000010,
        S_BIAS    = 9'b000000100,
        S_MAC     = 9'b000001000,
        S_DRAIN   = 9'b000010000,
        S_SAT     = 9'b000100000,
        S_ACT     = 9'b001000000,
        S_EMIT_RD = 9'b010000000,
        S_EMIT_LD = 9'b100000000
    } t_state;

    t_state                    r_state, n_state;
    logic [2:0]                r_l, n_l;
    logic [mlp_pkg::CNT_W-1:0] r_j, n_j;
    logic [mlp_pkg::CNT_W-1:0] r_k, n_k;
    logic                      r_drain, n_drain;

    logic [2:0]                layers;
    logic [mlp_pkg::CNT_W-1:0] nin;
    logic [mlp_pkg::CNT_W-1:0] nout;
    logic [mlp_pkg::CNT_W-1:0] nemit;
    logic [2:0]                next_l;
    mlp_pkg::t_region          prev_region;
    mlp_pkg::t_region          dst_region;
    mlp_pkg::t_region          emit_region;
    logic                      accept;

    function automatic logic [mlp_pkg::CNT_W-1:0] clip(input logic [mlp_pkg::CNT_W-1:0] w);
        return (w > mlp_pkg::CNT_W'(mlp_pkg::MAX_WIDTH)) ?
               mlp_pkg::CNT_W'(mlp_pkg::MAX_WIDTH) : w;
    endfunction

    assign layers = (i_cfg.layer_count > 3'(mlp_pkg::MAX_LAYERS)) ?
                    3'(mlp_pkg::MAX_LAYERS) : i_cfg.layer_count;
    assign next_l = r_l + 3'd1;
    assign nin    = clip(i_cfg.width[r_l]);
    assign nout   = (next_l > 3'(mlp_pkg::MAX_LAYERS)) ? '0 : clip(i_cfg.width[next_l]);
    assign nemit  = clip(i_cfg.width[layers]);

    // Layer l writes region a when l is even and b when odd; layer 0 reads the inputs.
    assign dst_region  = r_l[0] ? mlp_pkg::BUF_B : mlp_pkg::BUF_A;
    assign prev_region = (r_l == 3'd0) ? mlp_pkg::BUF_INPUT :
                         (r_l[0] ? mlp_pkg::BUF_A : mlp_pkg::BUF_B);
    assign emit_region = (layers == 3'd0) ? mlp_pkg::BUF_INPUT :
                         (layers[0] ? mlp_pkg::BUF_A : mlp_pkg::BUF_B);

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_l     = r_l;
        n_j     = r_j;
        n_k     = r_k;
        n_drain = r_drain;
        o_cmd   = '0;
        o_cmd.bias_addr = {r_l[1:0], r_j[mlp_pkg::IDX_W-1:0]};
        o_cmd.wt_addr   = {r_l[1:0], r_k[mlp_pkg::IDX_W-1:0], r_j[mlp_pkg::IDX_W-1:0]};
        o_cmd.buf_waddr = {dst_region, r_j[mlp_pkg::IDX_W-1:0]};
        o_cmd.out_index = r_j[mlp_pkg::IDX_W-1:0];
        o_cmd.out_last  = (r_j + mlp_pkg::CNT_W'(1)) == nemit;
        if (r_state == S_MAC) begin
            o_cmd.buf_raddr = {prev_region, r_k[mlp_pkg::IDX_W-1:0]};
        end else begin
            o_cmd.buf_raddr = {emit_region, r_j[mlp_pkg::IDX_W-1:0]};
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (mlp_pkg::t_op'(i_operation) == mlp_pkg::OP_RUN) begin
                        n_l     = '0;
                        n_j     = '0;
                        n_state = (layers == 3'd0) ? S_EMIT_RD : S_LAYER;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_LAYER: begin
                if (r_l == layers) begin
                    n_j     = '0;
                    n_state = S_EMIT_RD;
                end else if (r_j == nout) begin
                    n_l = next_l;
                    n_j = '0;
                end else begin
                    n_state = S_BIAS;
                end
            end
            S_BIAS: begin
                o_cmd.bias_rd = 1'b1;
                n_k     = '0;
                n_drain = 1'b0;
                n_state = (nin == '0) ? S_DRAIN : S_MAC;
            end
            S_MAC: begin
                o_cmd.mac_rd = 1'b1;
                o_cmd.buf_rd = 1'b1;
                n_k = r_k + mlp_pkg::CNT_W'(1);
                if (n_k == nin) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The r_drain flag holds this state until the last product has reached the accumulator.
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                o_cmd.fin_sat = 1'b1;
                n_state = S_ACT;
            end
            S_ACT: begin
                o_cmd.fin_wr = 1'b1;
                n_j     = r_j + mlp_pkg::CNT_W'(1);
                n_state = S_LAYER;
            end
            S_EMIT_RD: begin
                if (r_j == nemit) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.buf_rd = 1'b1;
                    n_state = S_EMIT_LD;
                end
            end
            S_EMIT_LD: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_j     = r_j + mlp_pkg::CNT_W'(1);
                    n_state = S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_l     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_l     <= n_l;
            r_j     <= n_j;
            r_k     <= n_k;
            r_drain <= n_drain;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mlp_dp.sv -----
// Datapath: weight, bias and layer memories, multiply-accumulate, rounding, activation, output.
// Depends on mlp_pkg and mlp_ram; obeys t_cmd from the sequencer and reports t_sts.
`default_nettype none

module mlp_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire mlp_pkg::t_cfg                       i_cfg,
    input  wire mlp_pkg::t_cmd                       i_cmd,
    output mlp_pkg::t_sts                            o_sts,
    input  wire logic [1:0]                          i_operation,
    input  wire logic [mlp_pkg::LAYER_W-1:0]         i_layer,
    input  wire logic [mlp_pkg::IDX_W-1:0]           i_source_index,
    input  wire logic [mlp_pkg::IDX_W-1:0]           i_target_index,
    input  wire logic signed [mlp_pkg::VAL_W-1:0]    i_value,
    input  wire logic                                i_out_ready,
    output logic                                     o_out_valid,
    output logic [mlp_pkg::IDX_W-1:0]                o_neuron_index,
    output logic signed [mlp_pkg::VAL_W-1:0]         o_neuron_value,
    output logic                                     o_last
);

    logic                             wt_we;
    logic                             bias_we;
    logic                             buf_we;
    logic [mlp_pkg::BUF_AW-1:0]       buf_waddr;
    logic [mlp_pkg::VAL_W-1:0]        buf_wdata;
    logic [mlp_pkg::VAL_W-1:0]        wt_rdata;
    logic [mlp_pkg::VAL_W-1:0]        bias_rdata;
    logic [mlp_pkg::VAL_W-1:0]        buf_rdata;
    logic signed [mlp_pkg::VAL_W-1:0] rd_val;

    logic [mlp_pkg::BUF_DEPTH-1:0]     r_buf_valid;
    logic                              r_rd_valid;
    logic                              r_bias_v;
    logic                              r_mac_v1;
    logic                              r_mac_v2;
    logic signed [mlp_pkg::PROD_W-1:0] r_prod;
    logic signed [mlp_pkg::ACC_W-1:0]  r_acc;
    logic signed [mlp_pkg::VAL_W-1:0]  r_q;
    logic signed [mlp_pkg::VAL_W-1:0]  r_tab;
    logic signed [mlp_pkg::ACC_W-1:0]  rounded;
    logic signed [35:0]                q_wide;
    logic signed [mlp_pkg::VAL_W-1:0]  q_sat;
    logic signed [32:0]                leak_prod;
    logic signed [33:0]                leak_rnd;
    logic signed [mlp_pkg::VAL_W-1:0]  act_val;
    logic signed [mlp_pkg::VAL_W-1:0]  tab_val;
    logic [mlp_pkg::TAB_AW-1:0]        tab_idx;

    logic                              r_out_valid;
    logic [mlp_pkg::IDX_W-1:0]         r_out_index;
    logic signed [mlp_pkg::VAL_W-1:0]  r_out_value;
    logic                              r_out_last;

    // Load decode: an item of a load kind writes straight into its store.
    assign wt_we   = i_cmd.load && (mlp_pkg::t_op'(i_operation) == mlp_pkg::OP_WEIGHT);
    assign bias_we = i_cmd.load && (mlp_pkg::t_op'(i_operation) == mlp_pkg::OP_BIAS);
    assign buf_we  = (i_cmd.load && (mlp_pkg::t_op'(i_operation) == mlp_pkg::OP_INPUT))
                     || i_cmd.fin_wr;
    assign buf_waddr = i_cmd.fin_wr ? i_cmd.buf_waddr : {mlp_pkg::BUF_INPUT, i_target_index};
    assign buf_wdata = i_cmd.fin_wr ? act_val : i_value;

    mlp_ram #(.WIDTH(mlp_pkg::VAL_W), .DEPTH(mlp_pkg::WT_DEPTH)) u_wt_ram (
        .i_clk   (i_clk),
        .i_we    (wt_we),
        .i_waddr ({i_layer, i_source_index, i_target_index}),
        .i_wdata (i_value),
        .i_re    (i_cmd.mac_rd),
        .i_raddr (i_cmd.wt_addr),
        .o_rdata (wt_rdata)
    );

    mlp_ram #(.WIDTH(mlp_pkg::VAL_W), .DEPTH(mlp_pkg::BIAS_DEPTH)) u_bias_ram (
        .i_clk   (i_clk),
        .i_we    (bias_we),
        .i_waddr ({i_layer, i_target_index}),
        .i_wdata (i_value),
        .i_re    (i_cmd.bias_rd),
        .i_raddr (i_cmd.bias_addr),
        .o_rdata (bias_rdata)
    );

    mlp_ram #(.WIDTH(mlp_pkg::VAL_W), .DEPTH(mlp_pkg::BUF_DEPTH)) u_buf_ram (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (buf_wdata),
        .i_re    (i_cmd.buf_rd),
        .i_raddr (i_cmd.buf_raddr),
        .o_rdata (buf_rdata)
    );

    // An entry never written since reset reads as zero.
    assign rd_val = r_rd_valid ? buf_rdata : '0;

    assign rounded = r_acc + mlp_pkg::ACC_W'(2048);
    assign q_wide  = rounded[mlp_pkg::ACC_W-1:12];

    always_comb begin
        if (q_wide > 36'sd32767) begin
            q_sat = 16'sh7fff;
        end else if (q_wide < -36'sd32768) begin
            q_sat = 16'sh8000;
        end else begin
            q_sat = q_wide[mlp_pkg::VAL_W-1:0];
        end
    end

    // The table entry is looked up from the saturated value and registered alongside it,
    // so each activation table is read like a ROM with registered data.
    assign tab_idx = q_sat[mlp_pkg::VAL_W-1:mlp_pkg::VAL_W-mlp_pkg::TAB_AW];

    always_comb begin
        case (i_cfg.act)
            mlp_pkg::ACT_TANH: tab_val = mlp_pkg::TANH_TAB[tab_idx];
            mlp_pkg::ACT_SINE: tab_val = mlp_pkg::SIN_TAB[tab_idx];
            default:           tab_val = mlp_pkg::SIG_TAB[tab_idx];
        endcase
    end

    assign leak_prod = r_q * $signed({1'b0, i_cfg.leak_slope});
    assign leak_rnd  = 34'(leak_prod) + 34'sd32768;

    always_comb begin
        if (i_cfg.act == mlp_pkg::ACT_LEAKY) begin
            if (!r_q[mlp_pkg::VAL_W-1] && (r_q != '0)) begin
                act_val = r_q;
            end else begin
                act_val = leak_rnd[31:16];
            end
        end else begin
            act_val = r_tab;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_valid <= '0;
            r_rd_valid  <= 1'b0;
            r_bias_v    <= 1'b0;
            r_mac_v1    <= 1'b0;
            r_mac_v2    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (buf_we) begin
                r_buf_valid[buf_waddr] <= 1'b1;
            end
            if (i_cmd.buf_rd) begin
                r_rd_valid <= r_buf_valid[i_cmd.buf_raddr];
            end
            r_bias_v <= i_cmd.bias_rd;
            r_mac_v1 <= i_cmd.mac_rd;
            r_mac_v2 <= r_mac_v1;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_mac_v1) begin
            r_prod <= rd_val * $signed(wt_rdata);
        end
        if (r_bias_v) begin
            r_acc <= {{(mlp_pkg::ACC_W - mlp_pkg::VAL_W - 12){bias_rdata[mlp_pkg::VAL_W-1]}},
                      bias_rdata, 12'd0};
        end else if (r_mac_v2) begin
            r_acc <= r_acc + mlp_pkg::ACC_W'(r_prod);
        end
        if (i_cmd.fin_sat) begin
            r_q   <= q_sat;
            r_tab <= tab_val;
        end
        if (i_cmd.out_load) begin
            r_out_index <= i_cmd.out_index;
            r_out_value <= rd_val;
            r_out_last  <= i_cmd.out_last;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_neuron_index = r_out_index;
    assign o_neuron_value = r_out_value;
    assign o_last         = r_out_last;

endmodule

`default_nettype wire

// ----- rtl/mlp_forward_inference.sv -----
// Load items (weight, bias, input element) are written while idle; ready is high whenever idle.
// A run item computes each neuron as a bias read, one product per neuron of the previous layer
// (bounded by the single weight memory read port feeding one multiplier), a drain, saturation
// and the activation write, then loads each result into the output register, waiting while
// the output is stalled; no new item meanwhile. Reset is synchronous, active low: control and
// the buffer valid bits clear and the configuration takes its defaults; weight and bias memories
// hold whatever they held and must be written before use.
`default_nettype none

module mlp_forward_inference (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mlp_in_if.sink     i_in,
    mlp_out_if.source  o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    // Configuration registers, one per 32-bit word.
    logic [2:0]                r_layer_count;
    logic [4:0][mlp_pkg::CNT_W-1:0] r_width;
    mlp_pkg::t_act             r_act;
    logic [15:0]               r_leak_slope;

    mlp_pkg::t_cfg cfg;
    mlp_pkg::t_cmd cmd;
    mlp_pkg::t_sts sts;
    logic          cfg_wr;
    mlp_pkg::t_reg reg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = mlp_pkg::t_reg'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_count <= 3'd1;
            r_width       <= {5{mlp_pkg::CNT_W'(1)}};
            r_act         <= mlp_pkg::ACT_SIGMOID;
            r_leak_slope  <= 16'd655;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                mlp_pkg::REG_LAYER_COUNT: r_layer_count <= pwdata[2:0];
                mlp_pkg::REG_INPUT_WIDTH: r_width[0] <= pwdata[mlp_pkg::CNT_W-1:0];
                mlp_pkg::REG_WIDTH_ONE:   r_width[1] <= pwdata[mlp_pkg::CNT_W-1:0];
                mlp_pkg::REG_WIDTH_TWO:   r_width[2] <= pwdata[mlp_pkg::CNT_W-1:0];
                mlp_pkg::REG_WIDTH_THREE: r_width[3] <= pwdata[mlp_pkg::CNT_W-1:0];
                mlp_pkg::REG_WIDTH_FOUR:  r_width[4] <= pwdata[mlp_pkg::CNT_W-1:0];
                mlp_pkg::REG_ACTIVATION:  r_act <= mlp_pkg::t_act'(pwdata[1:0]);
                mlp_pkg::REG_LEAK_SLOPE:  r_leak_slope <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (reg_sel)
            mlp_pkg::REG_LAYER_COUNT: prdata = 32'(r_layer_count);
            mlp_pkg::REG_INPUT_WIDTH: prdata = 32'(r_width[0]);
            mlp_pkg::REG_WIDTH_ONE:   prdata = 32'(r_width[1]);
            mlp_pkg::REG_WIDTH_TWO:   prdata = 32'(r_width[2]);
            mlp_pkg::REG_WIDTH_THREE: prdata = 32'(r_width[3]);
            mlp_pkg::REG_WIDTH_FOUR:  prdata = 32'(r_width[4]);
            mlp_pkg::REG_ACTIVATION:  prdata = 32'(r_act);
            mlp_pkg::REG_LEAK_SLOPE:  prdata = 32'(r_leak_slope);
            default:                  prdata = '0;
        endcase
    end

    assign cfg.layer_count = r_layer_count;
    assign cfg.width       = r_width;
    assign cfg.act         = r_act;
    assign cfg.leak_slope  = r_leak_slope;

    // The sequencer owns the input handshake; loads are decoded in the datapath
    // in the same cycle as the item is taken.
    mlp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_in.valid),
        .i_operation (i_in.operation),
        .o_ready     (i_in.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // The datapath holds every store and the output register, which lets a result
    // wait for the consumer while the sequencer fetches the next one.
    mlp_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_operation    (i_in.operation),
        .i_layer        (i_in.layer),
        .i_source_index (i_in.source_index),
        .i_target_index (i_in.target_index),
        .i_value        (i_in.value),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_neuron_index (o_out.neuron_index),
        .o_neuron_value (o_out.neuron_value),
        .o_last         (o_out.last)
    );

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for the perceptron inference engine: loads, runs and register writes.
// Depends on rtl/mlp_pkg.sv, rtl/mlp_if.sv and rtl/mlp_forward_inference.sv.
`timescale 1ns / 1ps

module testbench;
    import mlp_pkg::*;

    // Own copies of the fixed-point constants that the activation tables are built from.
    localparam longint unsigned ONE_Q31      = 64'd1 << 31;
    localparam longint unsigned E_INV_Q31    = 64'd790015084;
    localparam longint unsigned PI_Q28_TB    = 64'd843314857;
    localparam longint unsigned TWOPI_Q28_TB = 64'd1686629713;
    localparam longint unsigned HALFPI_Q28_TB = 64'd421657428;

    typedef struct {
        t_op                op;
        logic [1:0]         lay;
        logic [5:0]         src;
        logic [5:0]         tgt;
        logic signed [15:0] val;
        bit                 drain;   // hold the item back until every result has arrived
    } t_item;

    typedef struct {
        logic [5:0]         idx;
        logic signed [15:0] val;
        logic               last;
    } t_neuron;

    logic i_clk;
    logic i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mlp_in_if  in_ch ();
    mlp_out_if out_ch ();

    mlp_forward_inference uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // The predictor's view of the block: stores, configuration and activation tables.
    logic signed [15:0] weight_mem [WT_DEPTH];
    logic signed [15:0] bias_mem   [BIAS_DEPTH];
    logic signed [15:0] input_mem  [MAX_WIDTH];
    int                 sigmoid_lut [TABLE_SIZE];
    int                 tanh_lut    [TABLE_SIZE];
    int                 sine_lut    [TABLE_SIZE];
    int                 cfg_layers;
    int                 cfg_width [5];
    t_act               cfg_act;
    int                 cfg_leak;

    // Which store entries the stimulus has written, so that no run reads an unwritten one.
    bit weight_set [WT_DEPTH];
    bit bias_set   [BIAS_DEPTH];

    t_item   item_queue [$];
    t_neuron neuron_queue [$];
    int      error_count;
    int      items_made;

    // Sender burst state and receiver stall pattern.
    int burst_left;
    int gap_left;
    int rx_mode;
    int rx_count;
    t_neuron got;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // e^(-y) in Q31 for y in Q12, by a series for the fraction and powers of 1/e.
    function automatic longint unsigned exp_neg_q31(input longint unsigned y);
        longint unsigned whole;
        longint unsigned frac;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned r;
        whole = y >> 12;
        frac  = (y & 64'd4095) << 19;
        term  = ONE_Q31;
        acc   = ONE_Q31;
        for (int k = 1; k <= 16; k++) begin
            term = ((term * frac) >> 31) / 64'(k);
            acc  = acc + term;
        end
        r = ((64'd1 << 62) + acc / 2) / acc;
        for (longint unsigned k = 0; k < whole; k++) begin
            r = (r * E_INV_Q31 + (64'd1 << 30)) >> 31;
        end
        return r;
    endfunction

    // sin(x) in Q12, reduced into the first quadrant and summed as a Taylor series in Q28.
    function automatic int sin_q12(input int x);
        longint unsigned a;
        longint unsigned sq;
        longint unsigned term;
        longint unsigned acc;
        bit              neg;
        neg = (x < 0);
        a   = 64'(neg ? -x : x) << 16;
        if (a >= TWOPI_Q28_TB) a = a - TWOPI_Q28_TB;
        if (a >= PI_Q28_TB) begin
            a   = a - PI_Q28_TB;
            neg = !neg;
        end
        if (a > HALFPI_Q28_TB) a = PI_Q28_TB - a;
        sq   = (a * a) >> 28;
        term = a;
        acc  = a;
        for (int k = 1; k <= 10; k++) begin
            term = ((term * sq) >> 28) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) acc = acc - term;
            else acc = acc + term;
        end
        acc = (acc + (64'd1 << 15)) >> 16;
        if (acc > 64'd4096) acc = 64'd4096;
        return neg ? -int'(acc) : int'(acc);
    endfunction

    // Every table entry holds the function at the midpoint of its bucket of input codes.
    function automatic void fill_luts();
        int              lo;
        int              hi;
        int              mid;
        int              m;
        longint unsigned ax;
        longint unsigned e;
        longint unsigned den;
        longint unsigned e2;
        longint unsigned t;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            lo  = (i * 65536) / TABLE_SIZE;
            hi  = ((i + 1) * 65536) / TABLE_SIZE;
            mid = lo + (hi - lo) / 2;
            m   = (mid < 32768) ? mid : mid - 65536;
            ax  = 64'((m < 0) ? -m : m);
            e   = exp_neg_q31(ax);
            den = ONE_Q31 + e;
            if (m >= 0) sigmoid_lut[i] = int'(((ONE_Q31 << 12) + den / 2) / den);
            else sigmoid_lut[i] = int'(((e << 12) + den / 2) / den);
            e2  = exp_neg_q31(2 * ax);
            den = ONE_Q31 + e2;
            t   = (((ONE_Q31 - e2) << 12) + den / 2) / den;
            tanh_lut[i] = (m < 0) ? -int'(t) : int'(t);
            sine_lut[i] = sin_q12(m);
        end
    endfunction

    function automatic int clamp_width(input int w);
        return (w > MAX_WIDTH) ? MAX_WIDTH : w;
    endfunction

    function automatic longint saturate16(input longint x);
        if (x > 32767) return 32767;
        if (x < -32768) return -32768;
        return x;
    endfunction

    function automatic longint activate_q12(input longint x);
        logic [15:0] bits;
        int          slot;
        bits = x[15:0];
        slot = int'(bits[15:6]);
        case (cfg_act)
            ACT_SIGMOID: return longint'(sigmoid_lut[slot]);
            ACT_LEAKY:   return (x > 0) ? x : ((x * longint'(cfg_leak) + 32768) >>> 16);
            ACT_TANH:    return longint'(tanh_lut[slot]);
            default:     return longint'(sine_lut[slot]);
        endcase
    endfunction

    // Forward pass over the configured layers; the last layer's neurons become expectations.
    function automatic void forward_pass();
        logic signed [15:0] prev [MAX_WIDTH];
        logic signed [15:0] cur  [MAX_WIDTH];
        int                 layers;
        int                 nin;
        int                 nout;
        int                 n;
        longint             acc;
        longint             q;
        t_neuron            r;
        layers = (cfg_layers > MAX_LAYERS) ? MAX_LAYERS : cfg_layers;
        for (int k = 0; k < MAX_WIDTH; k++) prev[k] = input_mem[k];
        for (int l = 0; l < layers; l++) begin
            nin  = clamp_width(cfg_width[l]);
            nout = clamp_width(cfg_width[l + 1]);
            for (int j = 0; j < nout; j++) begin
                acc = longint'(bias_mem[l * MAX_WIDTH + j]) * 4096;
                for (int k = 0; k < nin; k++) begin
                    acc += longint'(prev[k])
                         * longint'(weight_mem[(l * MAX_WIDTH + k) * MAX_WIDTH + j]);
                end
                q = saturate16((acc + 2048) >>> 12);
                q = saturate16(activate_q12(q));
                cur[j] = q[15:0];
            end
            for (int j = 0; j < nout; j++) prev[j] = cur[j];
        end
        n = clamp_width(cfg_width[layers]);
        for (int j = 0; j < n; j++) begin
            r.idx  = j[5:0];
            r.val  = prev[j];
            r.last = (j == n - 1);
            neuron_queue.push_back(r);
        end
    endfunction

    function automatic void apply_item(input t_item it);
        case (it.op)
            OP_WEIGHT: weight_mem[{it.lay, it.src, it.tgt}] = it.val;
            OP_BIAS:   bias_mem[{it.lay, it.tgt}] = it.val;
            OP_INPUT:  input_mem[it.tgt] = it.val;
            default:   forward_pass();
        endcase
    endfunction

    function automatic void report(input string what, input t_neuron e, input t_neuron a);
        error_count++;
        if (error_count <= 10) begin
            $display("mismatch (%s): expected idx %0d val %0d last %0d,", what,
                     e.idx, e.val, e.last);
            $display("    got idx %0d val %0d last %0d", a.idx, a.val, a.last);
        end
    endfunction

    // Value mix: the two extremes, zero, full-range codes and modest Q4.12 values.
    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3, 4:    return 16'($urandom);
            default: return 16'($urandom_range(0, 8191)) - 16'sd4096;
        endcase
    endfunction

    function automatic void push_item(input t_op op, input int lay, input int src, input int tgt,
                                      input logic signed [15:0] v, input bit drain);
        t_item it;
        it.op    = op;
        it.lay   = lay[1:0];
        it.src   = src[5:0];
        it.tgt   = tgt[5:0];
        it.val   = v;
        it.drain = drain;
        if (op == OP_WEIGHT) weight_set[{it.lay, it.src, it.tgt}] = 1'b1;
        if (op == OP_BIAS) bias_set[{it.lay, it.tgt}] = 1'b1;
        item_queue.push_back(it);
        items_made++;
    endfunction

    // Queues a run, preceded by loads for every weight and bias entry that it reads and has not been
    // written, a few fresh input elements, some overwrites and the odd load to an unrelated address.
    function automatic void queue_run(input bit drain);
        int layers;
        int nin;
        int nout;
        int a;
        layers = (cfg_layers > MAX_LAYERS) ? MAX_LAYERS : cfg_layers;
        for (int l = 0; l < layers; l++) begin
            nin  = clamp_width(cfg_width[l]);
            nout = clamp_width(cfg_width[l + 1]);
            for (int j = 0; j < nout; j++) begin
                if (!bias_set[l * MAX_WIDTH + j]) push_item(OP_BIAS, l, 0, j, pick_value(), 0);
                for (int k = 0; k < nin; k++) begin
                    a = (l * MAX_WIDTH + k) * MAX_WIDTH + j;
                    if (!weight_set[a] || $urandom_range(0, 15) == 0) begin
                        push_item(OP_WEIGHT, l, k, j, pick_value(), 0);
                    end
                end
            end
        end
        repeat ($urandom_range(0, 3)) begin
            push_item(OP_INPUT, 0, $urandom_range(0, 63),
                      $urandom_range(0, clamp_width(cfg_width[0]) + 1) % MAX_WIDTH,
                      pick_value(), 0);
        end
        if ($urandom_range(0, 3) == 0) begin
            push_item(t_op'($urandom_range(0, 2)), $urandom_range(0, 3), $urandom_range(0, 63),
                      $urandom_range(0, 63), pick_value(), 0);
        end
        push_item(OP_RUN, $urandom_range(0, 3), $urandom_range(0, 63), $urandom_range(0, 63),
                  16'($urandom), drain);
    endfunction

    task automatic reg_write(input t_reg r, input int v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input int lc, input int w0, input int w1, input int w2,
                              input int w3, input int w4, input t_act act, input int leak);
        reg_write(REG_LAYER_COUNT, lc);
        reg_write(REG_INPUT_WIDTH, w0);
        reg_write(REG_WIDTH_ONE, w1);
        reg_write(REG_WIDTH_TWO, w2);
        reg_write(REG_WIDTH_THREE, w3);
        reg_write(REG_WIDTH_FOUR, w4);
        reg_write(REG_ACTIVATION, act);
        reg_write(REG_LEAK_SLOPE, leak);
        cfg_layers   = lc & 7;
        cfg_width[0] = w0 & 127;
        cfg_width[1] = w1 & 127;
        cfg_width[2] = w2 & 127;
        cfg_width[3] = w3 & 127;
        cfg_width[4] = w4 & 127;
        cfg_act      = act;
        cfg_leak     = leak & 16'hFFFF;
    endtask

    // A run with an empty last layer emits nothing, so after the last result the block may
    // still be busy: a short pause, then ready high, shows that it has finished.
    task automatic wait_idle();
        while (item_queue.size() != 0 || in_ch.valid || neuron_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    function automatic int rand_width();
        case ($urandom_range(0, 11))
            0:       return 0;
            1:       return $urandom_range(9, 16);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    // Sender: bursts of random length separated by random gaps, with some gapless stretches.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            burst_left  <= 0;
            gap_left    <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                apply_item(item_queue.pop_front());
            end
            if (in_ch.valid && !in_ch.ready) begin
                // Item still on offer; hold it.
            end else if (gap_left > 0) begin
                in_ch.valid <= 1'b0;
                gap_left    <= gap_left - 1;
            end else if (item_queue.size() != 0 &&
                         (!item_queue[0].drain || neuron_queue.size() == 0)) begin
                in_ch.valid        <= 1'b1;
                in_ch.operation    <= item_queue[0].op;
                in_ch.layer        <= item_queue[0].lay;
                in_ch.source_index <= item_queue[0].src;
                in_ch.target_index <= item_queue[0].tgt;
                in_ch.value        <= item_queue[0].val;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: its own stall pattern, drawn from three modes, and the result checker.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_mode      <= 0;
            rx_count     <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got.idx  = out_ch.neuron_index;
                got.val  = out_ch.neuron_value;
                got.last = out_ch.last;
                if (neuron_queue.size() == 0) begin
                    report("no result expected", got, got);
                end else if (neuron_queue[0].idx !== got.idx || neuron_queue[0].val !== got.val
                             || neuron_queue[0].last !== got.last) begin
                    report("field", neuron_queue.pop_front(), got);
                end else begin
                    void'(neuron_queue.pop_front());
                end
            end
            rx_count <= rx_count + 1;
            if (rx_count % 64 == 63) rx_mode <= $urandom_range(0, 2);
            case (rx_mode)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= $urandom_range(0, 1);
                default: out_ch.ready <= (rx_count % 11) < 2;
            endcase
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_ch.valid        = 1'b0;
        in_ch.operation    = OP_WEIGHT;
        in_ch.layer        = '0;
        in_ch.source_index = '0;
        in_ch.target_index = '0;
        in_ch.value        = '0;
        out_ch.ready       = 1'b0;
        error_count        = 0;
        items_made         = 0;
        for (int k = 0; k < MAX_WIDTH; k++) input_mem[k] = '0;
        for (int k = 0; k < WT_DEPTH; k++) weight_set[k] = 1'b0;
        for (int k = 0; k < BIAS_DEPTH; k++) bias_set[k] = 1'b0;
        cfg_layers = 1;
        for (int k = 0; k < 5; k++) cfg_width[k] = 1;
        cfg_act  = ACT_SIGMOID;
        cfg_leak = 655;
        fill_luts();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Single neuron with the extremes of the value field; the first run waits for
        // the pipeline to drain before it is offered.
        wait_idle();
        set_config(1, 1, 1, 1, 1, 1, ACT_SIGMOID, 655);
        push_item(OP_INPUT, 0, 0, 0, 16'sh7FFF, 0);
        push_item(OP_WEIGHT, 0, 0, 0, 16'sd4096, 0);
        push_item(OP_BIAS, 0, 0, 0, 16'sh0000, 0);
        queue_run(1);
        push_item(OP_INPUT, 0, 0, 0, 16'sh8000, 0);
        push_item(OP_WEIGHT, 0, 0, 0, 16'sh7FFF, 0);
        queue_run(0);

        // Leaky slope at both ends of its range.
        wait_idle();
        set_config(1, 2, 2, 1, 1, 1, ACT_LEAKY, 0);
        queue_run(0);
        queue_run(0);
        wait_idle();
        set_config(2, 2, 2, 3, 1, 1, ACT_LEAKY, 65535);
        queue_run(0);
        queue_run(0);

        // No layers: the input layer comes back unchanged.
        wait_idle();
        set_config(0, 5, 1, 1, 1, 1, ACT_TANH, 1);
        push_item(OP_INPUT, 0, 0, 4, 16'sh8000, 0);
        queue_run(0);

        // Layer count above the maximum, an empty layer, and a width above the limit.
        wait_idle();
        set_config(7, 2, 3, 0, 2, 100, ACT_SINE, 12345);
        queue_run(0);

        // An empty last layer: the run produces no result at all.
        wait_idle();
        set_config(2, 3, 2, 0, 1, 1, ACT_SIGMOID, 655);
        queue_run(0);

        // Widest input layer.
        wait_idle();
        set_config(1, 64, 1, 1, 1, 1, ACT_LEAKY, 32768);
        for (int k = 0; k < MAX_WIDTH; k++) push_item(OP_INPUT, 0, 0, k, pick_value(), 0);
        queue_run(0);

        // Random phases of small networks until enough items have been made.
        while (items_made < 400) begin
            wait_idle();
            set_config(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4),
                       rand_width(), rand_width(), rand_width(), rand_width(), rand_width(),
                       t_act'($urandom_range(0, 3)),
                       ($urandom_range(0, 4) == 0) ? 65535 * $urandom_range(0, 1) : $urandom);
            repeat ($urandom_range(2, 5)) queue_run($urandom_range(0, 7) == 0);
        end

        wait_idle();
        repeat (100) @(posedge i_clk);
        if (error_count == 0 && neuron_queue.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
